// File: src/wwhf_pkg.sv
// Shared constants, codes and types for the weighted window hole fill block.
package wwhf_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_WIDTH        = 1024;
    localparam int DEF_MAX_HEIGHT       = 1024;
    localparam int DEF_MAX_RADIUS       = 3;
    localparam int DEF_VALUE_BITS       = 16;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;

    // Configuration register indexes and field widths
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_RADIUS = 2'd2;
    localparam int RADIUS_FIELD_BITS = 2;

    // Reset values of the registers
    localparam logic [CFG_DATA_BITS-1:0]     RST_FRAME_WIDTH   = 11'd1024;
    localparam logic [CFG_DATA_BITS-1:0]     RST_FRAME_HEIGHT  = 11'd1024;
    localparam logic [RADIUS_FIELD_BITS-1:0] RST_KERNEL_RADIUS = 2'd1;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_GATHER,
        B_DRAIN,
        B_PREP,
        B_DIV,
        B_PUSH
    } t_back_state;

endpackage

// File: src/wwhf_fifo.sv
// Two-entry queue used between front and back end and in front of the result ports.
module wwhf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop)  r_rptr <= !r_rptr;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end
endmodule

// File: src/wwhf_front.sv
// Front end: accepts items, keeps raster positions, writes the line store, issues window jobs.
module wwhf_front #(
    parameter int MAX_WIDTH  = wwhf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wwhf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = wwhf_pkg::DEF_MAX_RADIUS,
    parameter int VALUE_BITS = wwhf_pkg::DEF_VALUE_BITS,
    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int SB = $clog2(LINE_ROWS),
    localparam int RB = $clog2(MAX_RADIUS + 1),
    localparam int AB = $clog2(LINE_ROWS * MAX_WIDTH),
    localparam int JW = CB + SB + RB + 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [wwhf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [wwhf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic                                 i_kind,
    input  logic [VALUE_BITS-1:0]                i_pixel_value,
    input  logic                                 i_pixel_missing,
    input  logic                                 i_jq_empty,
    input  logic                                 i_back_busy,
    output logic                                 o_jq_push,
    output logic [JW-1:0]                        o_job,
    output logic                                 o_mem_we,
    output logic [AB-1:0]                        o_mem_addr,
    output logic [VALUE_BITS:0]                  o_mem_data
);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int RWB = $clog2(MAX_HEIGHT);
    localparam int PB = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

    logic [wwhf_pkg::CFG_DATA_BITS-1:0]     r_fw, r_fh;
    logic [wwhf_pkg::RADIUS_FIELD_BITS-1:0] r_kr;
    logic [CB-1:0]  r_in_col, r_out_col, n_in_col, n_out_col;
    logic [RWB-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic [SB-1:0]  r_in_slot, r_out_slot, n_in_slot, n_out_slot;
    logic [PB-1:0]  r_pend, n_pend, thr;
    logic [WB-1:0]  w_eff;
    logic [HB-1:0]  h_eff;
    logic [RB-1:0]  r_eff;
    logic           acc, is_pix, emit, interior, last;

    // Clamp registers to usable values
    always_comb begin
        if (r_fw == '0)                 w_eff = WB'(1);
        else if (int'(r_fw) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
        else                            w_eff = WB'(r_fw);
        if (r_fh == '0)                  h_eff = HB'(1);
        else if (int'(r_fh) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
        else                             h_eff = HB'(r_fh);
        if (int'(r_kr) > MAX_RADIUS) r_eff = RB'(MAX_RADIUS);
        else                         r_eff = RB'(r_kr);
        thr = PB'(PB'(r_eff) * PB'(w_eff)) + PB'(r_eff);
    end

    // Hold input while a job still reads the line store
    assign o_full = !i_jq_empty || i_back_busy;
    assign acc    = i_push && !o_full;
    assign is_pix = (i_kind == wwhf_pkg::KIND_PIXEL);

    // Decide emit and classify the center
    always_comb begin
        if (is_pix) emit = (r_pend + PB'(1)) > thr;
        else        emit = (r_in_row == '0) && (r_in_col == '0) && (r_pend != '0);
        interior = ((HB+1)'(r_out_row) >= (HB+1)'(r_eff))
                && (((HB+1)'(r_out_row) + (HB+1)'(r_eff)) < (HB+1)'(h_eff))
                && ((WB+1)'(r_out_col) >= (WB+1)'(r_eff))
                && (((WB+1)'(r_out_col) + (WB+1)'(r_eff)) < (WB+1)'(w_eff));
        last = ((HB+1)'(r_out_row) + (HB+1)'(1) == (HB+1)'(h_eff))
            && ((WB+1)'(r_out_col) + (WB+1)'(1) == (WB+1)'(w_eff));
    end

    assign o_jq_push  = acc && emit;
    assign o_job      = {last, interior, r_eff, r_out_slot, r_out_col};
    assign o_mem_we   = acc && is_pix;
    assign o_mem_addr = AB'(AB'(r_in_slot) * AB'(MAX_WIDTH)) + AB'(r_in_col);
    assign o_mem_data = i_pixel_missing ? {1'b1, {VALUE_BITS{1'b0}}}
                                        : {1'b0, i_pixel_value};

    // Advance raster positions
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        n_pend     = r_pend;
        if (acc && is_pix) begin
            if ((WB+1)'(r_in_col) + (WB+1)'(1) >= (WB+1)'(w_eff)) begin
                n_in_col  = '0;
                n_in_slot = (int'(r_in_slot) == LINE_ROWS - 1) ? '0 : r_in_slot + SB'(1);
                if ((HB+1)'(r_in_row) + (HB+1)'(1) >= (HB+1)'(h_eff)) n_in_row = '0;
                else n_in_row = r_in_row + RWB'(1);
            end else begin
                n_in_col = r_in_col + CB'(1);
            end
            if (!emit) n_pend = r_pend + PB'(1);
        end else if (acc && emit) begin
            n_pend = r_pend - PB'(1);
        end
        if (acc && emit) begin
            if ((WB+1)'(r_out_col) + (WB+1)'(1) >= (WB+1)'(w_eff)) begin
                n_out_col  = '0;
                n_out_slot = (int'(r_out_slot) == LINE_ROWS - 1) ? '0 : r_out_slot + SB'(1);
                if ((HB+1)'(r_out_row) + (HB+1)'(1) >= (HB+1)'(h_eff)) n_out_row = '0;
                else n_out_row = r_out_row + RWB'(1);
            end else begin
                n_out_col = r_out_col + CB'(1);
            end
        end
    end

    // Write registers and restart the stream on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= wwhf_pkg::RST_FRAME_WIDTH;
            r_fh       <= wwhf_pkg::RST_FRAME_HEIGHT;
            r_kr       <= wwhf_pkg::RST_KERNEL_RADIUS;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pend     <= '0;
        end else if (i_cfg_valid && (i_cfg_index inside {wwhf_pkg::CFG_FRAME_WIDTH,
                     wwhf_pkg::CFG_FRAME_HEIGHT, wwhf_pkg::CFG_KERNEL_RADIUS})) begin
            case (i_cfg_index)
                wwhf_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                wwhf_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                default: r_kr <= i_cfg_data[wwhf_pkg::RADIUS_FIELD_BITS-1:0];
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pend     <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            r_pend     <= n_pend;
        end
    end
endmodule

// File: src/wwhf_back.sv
// Back end: line store, window gather with weighted accumulation, and serial divider.
module wwhf_back #(
    parameter int MAX_WIDTH        = wwhf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS       = wwhf_pkg::DEF_MAX_RADIUS,
    parameter int VALUE_BITS       = wwhf_pkg::DEF_VALUE_BITS,
    parameter int WEIGHT_FRAC_BITS = wwhf_pkg::DEF_WEIGHT_FRAC_BITS,
    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1,
    localparam int CB = $clog2(MAX_WIDTH),
    localparam int SB = $clog2(LINE_ROWS),
    localparam int RB = $clog2(MAX_RADIUS + 1),
    localparam int AB = $clog2(LINE_ROWS * MAX_WIDTH),
    localparam int JW = CB + SB + RB + 2,
    localparam int OW = VALUE_BITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mem_we,
    input  logic [AB-1:0]       i_mem_addr,
    input  logic [VALUE_BITS:0] i_mem_data,
    input  logic [JW-1:0]       i_job,
    input  logic                i_jq_empty,
    output logic                o_jq_pop,
    output logic                o_busy,
    input  logic                i_of_full,
    output logic                o_of_push,
    output logic [OW-1:0]       o_of_data
);
    localparam int DB = $clog2(LINE_ROWS);
    localparam int FW = WEIGHT_FRAC_BITS + 1;
    localparam int PW = VALUE_BITS + FW + 1;
    localparam int NW = PW + $clog2(LINE_ROWS * LINE_ROWS);
    localparam int DW = FW + $clog2(LINE_ROWS * LINE_ROWS);
    localparam int KB = $clog2(NW);

    logic [VALUE_BITS:0] r_mem [LINE_ROWS * MAX_WIDTH];

    // Weight table: 2^F / distance, distance = index + 1
    logic [FW-1:0] w_tab [LINE_ROWS];
    for (genvar g = 0; g < LINE_ROWS; g++) begin : g_wtab
        localparam int WEIGHT_VAL = (2 ** WEIGHT_FRAC_BITS) / (g + 1);
        assign w_tab[g] = FW'(WEIGHT_VAL);
    end

    wwhf_pkg::t_back_state r_state, n_state;

    logic [CB-1:0]  r_col;
    logic [SB-1:0]  r_slot;
    logic [RB-1:0]  r_rad;
    logic           r_int, r_last;
    logic [DB-1:0]  r_dy, r_dx, lo, hi;
    logic           r_rd_vld, r_rd_ctr, r_p_vld, r_neg, r_use_q;
    logic [DB-1:0]  r_rd_wi;
    logic [VALUE_BITS:0] r_rd_data, r_ctr;
    logic signed [PW-1:0] r_prod;
    logic [FW-1:0]  r_p_w;
    logic signed [NW-1:0] r_num;
    logic [DW-1:0]  r_den, r_rem;
    logic [NW-1:0]  r_q;
    logic [KB-1:0]  r_cnt;
    logic [VALUE_BITS-1:0] r_res_val;
    logic           r_res_miss;
    logic           issue, last_rd;
    logic [DB:0]    ady, adx;
    logic [DB-1:0]  wi;
    logic [DB+SB+1:0] slot_t;
    logic [SB-1:0]  rd_slot;
    logic [CB:0]    rd_col;
    logic [AB-1:0]  rd_addr;
    logic [DW:0]    rem_sh;
    logic [NW-1:0]  q_res;

    // Window bounds: full window when interior, center only otherwise
    assign lo = r_int ? '0 : DB'(r_rad);
    assign hi = r_int ? DB'(DB'(r_rad) << 1) : DB'(r_rad);
    assign last_rd = (r_dy == hi) && (r_dx == hi);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wwhf_pkg::B_IDLE:   if (!i_jq_empty) n_state = wwhf_pkg::B_GATHER;
            wwhf_pkg::B_GATHER: if (last_rd) n_state = wwhf_pkg::B_DRAIN;
            wwhf_pkg::B_DRAIN:  if (!r_rd_vld && !r_p_vld) n_state = wwhf_pkg::B_PREP;
            wwhf_pkg::B_PREP: begin
                if (r_int && r_den != '0) n_state = wwhf_pkg::B_DIV;
                else                      n_state = wwhf_pkg::B_PUSH;
            end
            wwhf_pkg::B_DIV:    if (int'(r_cnt) == NW - 1) n_state = wwhf_pkg::B_PUSH;
            wwhf_pkg::B_PUSH:   if (!i_of_full) n_state = wwhf_pkg::B_IDLE;
            default:            n_state = wwhf_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        issue     = (r_state == wwhf_pkg::B_GATHER);
        o_busy    = (r_state == wwhf_pkg::B_GATHER);
        o_jq_pop  = (r_state == wwhf_pkg::B_IDLE);
        o_of_push = (r_state == wwhf_pkg::B_PUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wwhf_pkg::B_IDLE;
        else          r_state <= n_state;
    end

    // Read address and distance index of the current tap
    always_comb begin
        ady = (r_dy >= DB'(r_rad)) ? (DB+1)'(r_dy - DB'(r_rad)) : (DB+1)'(DB'(r_rad) - r_dy);
        adx = (r_dx >= DB'(r_rad)) ? (DB+1)'(r_dx - DB'(r_rad)) : (DB+1)'(DB'(r_rad) - r_dx);
        wi  = DB'(ady + adx);
        slot_t = (DB+SB+2)'(r_slot) + (DB+SB+2)'(r_dy) + (DB+SB+2)'(LINE_ROWS)
               - (DB+SB+2)'(r_rad);
        if (int'(slot_t) >= LINE_ROWS) slot_t = slot_t - (DB+SB+2)'(LINE_ROWS);
        if (int'(slot_t) >= LINE_ROWS) slot_t = slot_t - (DB+SB+2)'(LINE_ROWS);
        rd_slot = SB'(slot_t);
        rd_col  = (CB+1)'(r_col) + (CB+1)'(r_dx) - (CB+1)'(r_rad);
        rd_addr = AB'(AB'(rd_slot) * AB'(MAX_WIDTH)) + AB'(rd_col[CB-1:0]);
    end

    // Line store: write from the front, read for the window
    always_ff @(posedge i_clk) begin
        if (i_mem_we) r_mem[i_mem_addr] <= i_mem_data;
        if (issue)    r_rd_data <= r_mem[rd_addr];
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_p_vld  <= r_rd_vld && !r_rd_data[VALUE_BITS];
        end
    end

    // Divider step
    always_comb begin
        rem_sh = {r_rem, r_q[NW-1]};
        q_res  = r_neg ? NW'(-r_q) : r_q;
    end

    // Job load, tap walk, accumulation and division
    always_ff @(posedge i_clk) begin
        if (r_state == wwhf_pkg::B_IDLE && !i_jq_empty) begin
            {r_last, r_int, r_rad, r_slot, r_col} <= i_job;
            r_dy  <= i_job[JW-2] ? '0 : DB'(i_job[CB+SB +: RB]);
            r_dx  <= i_job[JW-2] ? '0 : DB'(i_job[CB+SB +: RB]);
            r_num <= '0;
            r_den <= '0;
        end
        if (issue) begin
            r_rd_ctr <= (r_dy == DB'(r_rad)) && (r_dx == DB'(r_rad));
            r_rd_wi  <= wi;
            if (r_dx == hi) begin
                r_dx <= lo;
                r_dy <= r_dy + DB'(1);
            end else begin
                r_dx <= r_dx + DB'(1);
            end
        end
        // Capture center and form the weighted product
        if (r_rd_vld && r_rd_ctr) r_ctr <= r_rd_data;
        r_p_w  <= w_tab[r_rd_wi];
        r_prod <= PW'($signed(r_rd_data[VALUE_BITS-1:0]))
                * $signed({1'b0, w_tab[r_rd_wi]});
        // Sum present taps
        if (r_p_vld) begin
            r_num <= r_num + NW'(r_prod);
            r_den <= r_den + DW'(r_p_w);
        end
        // Set up the result or the divider
        if (r_state == wwhf_pkg::B_PREP) begin
            r_neg      <= r_num[NW-1];
            r_q        <= r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
            r_rem      <= '0;
            r_cnt      <= '0;
            r_use_q    <= r_int && (r_den != '0);
            r_res_miss <= r_ctr[VALUE_BITS];
            r_res_val  <= r_ctr[VALUE_BITS] ? '0 : r_ctr[VALUE_BITS-1:0];
        end
        // One quotient bit per cycle
        if (r_state == wwhf_pkg::B_DIV) begin
            r_cnt <= r_cnt + KB'(1);
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= DW'(rem_sh - {1'b0, r_den});
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= DW'(rem_sh);
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_of_data = r_use_q ? {r_last, 1'b0, q_res[VALUE_BITS-1:0]}
                               : {r_last, r_res_miss, r_res_val};
endmodule

// File: src/weighted_window_hole_fill_core.sv
// Flow: the back end reads a window of (2r+1)^2 taps for a center inside the frame and 1 tap
// on the border, and divides the sums of an interior window serially, one quotient bit per
// cycle. It finishes one result before it takes the next job. Input stalls while a job waits
// and reads the line store, and a full result queue stalls the back end. Reset (synchronous,
// active low) restores register defaults and clears positions, queues and sequencer; the line
// store is not cleared.
module weighted_window_hole_fill_core #(
    parameter int MAX_WIDTH        = wwhf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT       = wwhf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS       = wwhf_pkg::DEF_MAX_RADIUS,
    parameter int VALUE_BITS       = wwhf_pkg::DEF_VALUE_BITS,
    parameter int WEIGHT_FRAC_BITS = wwhf_pkg::DEF_WEIGHT_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wwhf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [wwhf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_kind,
    input  logic [VALUE_BITS-1:0]               i_pixel_value,
    input  logic                                i_pixel_missing,
    output logic                                empty,
    input  logic                                pop,
    output logic [VALUE_BITS-1:0]               o_out_value,
    output logic                                o_out_missing,
    output logic                                o_out_last
);
    localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int AB = $clog2(LINE_ROWS * MAX_WIDTH);
    localparam int JW = $clog2(MAX_WIDTH) + $clog2(LINE_ROWS) + $clog2(MAX_RADIUS + 1) + 2;
    localparam int OW = VALUE_BITS + 2;

    logic                jq_push, jq_full, jq_pop, jq_empty, back_busy;
    logic [JW-1:0]       job_in, job_out;
    logic                mem_we;
    logic [AB-1:0]       mem_addr;
    logic [VALUE_BITS:0] mem_data;
    logic                of_push, of_full;
    logic [OW-1:0]       of_in, of_out;

    // Registers take a beat in any cycle
    assign o_cfg_ready = 1'b1;

    wwhf_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS), .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_push(push), .o_full(full), .i_kind, .i_pixel_value, .i_pixel_missing,
        .i_jq_empty(jq_empty), .i_back_busy(back_busy),
        .o_jq_push(jq_push), .o_job(job_in),
        .o_mem_we(mem_we), .o_mem_addr(mem_addr), .o_mem_data(mem_data)
    );

    wwhf_fifo #(.WIDTH(JW)) u_jobq (
        .i_clk, .i_rst_n, .i_push(jq_push), .i_data(job_in), .o_full(jq_full),
        .i_pop(jq_pop), .o_data(job_out), .o_empty(jq_empty)
    );

    wwhf_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS),
        .VALUE_BITS(VALUE_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_mem_we(mem_we), .i_mem_addr(mem_addr), .i_mem_data(mem_data),
        .i_job(job_out), .i_jq_empty(jq_empty), .o_jq_pop(jq_pop), .o_busy(back_busy),
        .i_of_full(of_full), .o_of_push(of_push), .o_of_data(of_in)
    );

    wwhf_fifo #(.WIDTH(OW)) u_outq (
        .i_clk, .i_rst_n, .i_push(of_push), .i_data(of_in), .o_full(of_full),
        .i_pop(pop), .o_data(of_out), .o_empty(empty)
    );

    // The job queue never fills: the front waits for it to drain
    logic unused_jq_full;
    assign unused_jq_full = jq_full;

    assign o_out_last    = of_out[OW-1];
    assign o_out_missing = of_out[OW-2];
    assign o_out_value   = of_out[VALUE_BITS-1:0];
endmodule

// File: src/wwhf_checker.sv
// Port-level checks of the hole fill core, bound to the top level.
module wwhf_checker #(
    parameter int VALUE_BITS = wwhf_pkg::DEF_VALUE_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [VALUE_BITS-1:0] o_out_value,
    input logic                  o_out_missing
);
    // Come out of reset empty and ready for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not clear after reset");

    // A missing result carries a zero value
    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_missing) |-> (o_out_value == '0))
        else $error("missing result with nonzero value");

    // Hold a waiting result until it is taken
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_value) && $stable(o_out_missing)))
        else $error("waiting result changed");
endmodule

bind weighted_window_hole_fill_core wwhf_checker #(.VALUE_BITS(VALUE_BITS)) u_wwhf_checker (.*);
